### hdl/mcag_pkg.sv
// Package for the midpoint circle arc generator.
// Holds the canvas size, the input mode codes and the arc shape codes.
// No dependencies.
`timescale 1ns / 1ps

package mcag_pkg;

  localparam int CANVAS_SIZE = 128;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [1:0] ARC_FULL  = 2'd0;
  localparam logic [1:0] ARC_UPPER = 2'd1;
  localparam logic [1:0] ARC_LOWER = 2'd2;

  localparam logic [2:0] LAST_IDX_HALF = 3'd3;
  localparam logic [2:0] LAST_IDX_FULL = 3'd7;

  localparam logic signed [9:0] CANVAS_LIM = 10'(CANVAS_SIZE);

endpackage

### hdl/midpoint_circle_arc_generator.sv
// Midpoint circle arc generator top level.
// Depends on mcag_pkg.
//
// Usage: the input channel (in_valid/in_stall) takes items. mode START loads
// centre, radius and arc shape and gives no result. mode STEP advances the
// arc by one point and gives the mirrored pixels of that point, one result
// per cycle on the output channel (out_valid/out_stall) when it does not
// stall: 8 for a full circle, 4 for a half, the final one marked by last.
// A step that ends the arc, or finds no arc loaded, gives one result with
// pixel_valid low. A step transfer is registered in the pixel sequencer
// before its first result is loaded into the single output register, which
// emits one pixel per cycle while the receiver does not stall; start items
// give no result. The next item is taken in the cycle the last pixel of
// the current one leaves the generator.
// Reset clears the arc state, the sequencer and out_valid; the block is idle.
// When the receiver stalls, the output register holds its result and the
// input side stalls once the pixel sequence is stopped.
`timescale 1ns / 1ps

module midpoint_circle_arc_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [6:0]        centre_x,
  input  logic [6:0]        centre_y,
  input  logic [6:0]        radius,
  input  logic [1:0]        arc_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] pixel_x,
  output logic signed [8:0] pixel_y,
  output logic              on_canvas,
  output logic              pixel_valid,
  output logic              last
);
  import mcag_pkg::*;

  logic [6:0]         held_centre_x;
  logic [6:0]         held_centre_y;
  logic [1:0]         held_arc_kind;
  logic signed [7:0]  offset_x;
  logic signed [7:0]  offset_y;
  logic signed [10:0] decision;
  logic               arc_active;

  logic               gen_busy;
  logic               gen_dead;
  logic [2:0]         gen_idx;

  logic               in_xfer;
  logic               out_load;
  logic               gen_last;
  logic               half_arc;

  logic signed [7:0]  x_inc;
  logic signed [7:0]  y_new;
  logic signed [10:0] x_ext;
  logic signed [10:0] y_ext;
  logic signed [10:0] decision_next;
  logic               arc_ends;

  logic [2:0]         full_idx;
  logic signed [9:0]  u_ext;
  logic signed [9:0]  v_ext;
  logic signed [9:0]  px_full;
  logic signed [9:0]  py_full;
  logic               px_on;

  // step arithmetic
  always_comb begin
    x_inc = offset_x + 8'sd1;
    y_new = (decision >= 11'sd0) ? (offset_y - 8'sd1) : offset_y;
    x_ext = 11'(x_inc);
    y_ext = 11'(y_new);
    if (decision >= 11'sd0) begin
      decision_next = decision + (x_ext <<< 1) + 11'sd1 - (y_ext <<< 1);
    end else begin
      decision_next = decision + (x_ext <<< 1) + 11'sd1;
    end
    arc_ends = x_inc > y_new;
  end

  // pixel selection
  always_comb begin
    half_arc = (held_arc_kind == ARC_UPPER) || (held_arc_kind == ARC_LOWER);
    case (held_arc_kind)
      ARC_UPPER: full_idx = {gen_idx[1], 1'b1, gen_idx[0]};
      ARC_LOWER: full_idx = {gen_idx[1], 1'b0, gen_idx[0]};
      default:   full_idx = gen_idx;
    endcase
    u_ext = full_idx[2] ? 10'(offset_y) : 10'(offset_x);
    v_ext = full_idx[2] ? 10'(offset_x) : 10'(offset_y);
    px_full = full_idx[0] ? (10'(held_centre_x) - u_ext) : (10'(held_centre_x) + u_ext);
    py_full = full_idx[1] ? (10'(held_centre_y) - v_ext) : (10'(held_centre_y) + v_ext);
    px_on = (px_full >= 10'sd0) && (px_full < CANVAS_LIM) &&
            (py_full >= 10'sd0) && (py_full < CANVAS_LIM);
    gen_last = gen_dead || (gen_idx == (half_arc ? LAST_IDX_HALF : LAST_IDX_FULL));
  end

  assign out_load = !out_valid || !out_stall;
  assign in_stall = gen_busy && !(out_load && gen_last);
  assign in_xfer  = in_valid && !in_stall;

  // arc state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_centre_x <= '0;
      held_centre_y <= '0;
      held_arc_kind <= ARC_FULL;
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      arc_active    <= 1'b0;
    end else if (in_xfer) begin
      if (mode == MODE_START) begin
        held_centre_x <= centre_x;
        held_centre_y <= centre_y;
        held_arc_kind <= arc_kind;
        offset_x      <= '0;
        offset_y      <= 8'(radius);
        decision      <= 11'sd1 - 11'(radius);
        arc_active    <= 1'b1;
      end else if (arc_active) begin
        offset_x   <= x_inc;
        offset_y   <= y_new;
        decision   <= decision_next;
        arc_active <= !arc_ends;
      end
    end
  end

  // pixel sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_busy <= 1'b0;
      gen_dead <= 1'b0;
      gen_idx  <= '0;
    end else if (in_xfer && (mode == MODE_STEP)) begin
      gen_busy <= 1'b1;
      gen_idx  <= '0;
      gen_dead <= !arc_active || arc_ends;
    end else if (out_load && gen_busy) begin
      gen_idx <= gen_idx + 3'd1;
      if (gen_last) begin
        gen_busy <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= gen_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && gen_busy) begin
      pixel_x     <= gen_dead ? 9'sd0 : 9'(px_full);
      pixel_y     <= gen_dead ? 9'sd0 : 9'(py_full);
      on_canvas   <= !gen_dead && px_on;
      pixel_valid <= !gen_dead;
      last        <= gen_last;
    end
  end

endmodule

### hdl/mcag_checker.sv
// Port checker for the midpoint circle arc generator, bound to the top level.
// Uses no package itself; the top level it is bound to depends on mcag_pkg.
`timescale 1ns / 1ps

module mcag_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [8:0] pixel_x,
  input logic signed [8:0] pixel_y,
  input logic              on_canvas,
  input logic              pixel_valid,
  input logic              last
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
    $stable(last))
    else $error("stalled transfer changed");

  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> last)
    else $error("invalid result not marked last");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_x == 9'sd0 && pixel_y == 9'sd0 && !on_canvas)
    else $error("invalid result carries pixel data");

  a_canvas_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && on_canvas |-> pixel_valid && !pixel_x[8] && !pixel_y[8] &&
    pixel_x[7] == 1'b0 && pixel_y[7] == 1'b0)
    else $error("on_canvas set off the canvas");

endmodule

bind midpoint_circle_arc_generator mcag_checker u_mcag_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .on_canvas   (on_canvas),
  .pixel_valid (pixel_valid),
  .last        (last)
);
